FILE: src/bcbc_pkg.sv
// shared constants and types for the border versus center brightness compare
`default_nettype none
package bcbc_pkg;

  localparam int MAX_ROWS = 1024;
  localparam int MAX_COLS = 1024;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);

  localparam int CFG_W    = 11;
  localparam int CADDR_W  = 2;
  localparam int PIX_W    = 8;
  localparam int HITS_W   = 3;

  localparam int BSUM_W   = 29;
  localparam int BCNT_W   = 22;
  localparam int CSUM_W   = 28;
  localparam int CCNT_W   = 21;

  localparam int IN_TDATA_W  = 8;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_FIELD_W = 1 + BSUM_W + BCNT_W + CSUM_W + CCNT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam int LHS_W    = BSUM_W + CCNT_W;
  localparam int RHS_W    = CSUM_W + BCNT_W;
  localparam int PROD_W   = (LHS_W > RHS_W) ? LHS_W : RHS_W;

  // configuration register indexes
  localparam logic [CADDR_W-1:0] REG_FRAME_ROWS  = 2'd0;
  localparam logic [CADDR_W-1:0] REG_FRAME_COLS  = 2'd1;
  localparam logic [CADDR_W-1:0] REG_MARGIN_ROWS = 2'd2;
  localparam logic [CADDR_W-1:0] REG_MARGIN_COLS = 2'd3;

  localparam logic [CFG_W-1:0] RST_FRAME_ROWS  = 11'd480;
  localparam logic [CFG_W-1:0] RST_FRAME_COLS  = 11'd640;
  localparam logic [CFG_W-1:0] RST_MARGIN_ROWS = 11'd29;
  localparam logic [CFG_W-1:0] RST_MARGIN_COLS = 11'd96;

  typedef struct packed {
    logic [CCNT_W-1:0] ccnt;
    logic [CSUM_W-1:0] csum;
    logic [BCNT_W-1:0] bcnt;
    logic [BSUM_W-1:0] bsum;
  } totals_t;

  // clamp an 11-bit size register to 1..top
  function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                  input logic [CFG_W-1:0] top);
    logic [CFG_W-1:0] s;
    s = v;
    if (s == '0) s = {{(CFG_W-1){1'b0}}, 1'b1};
    if (s > top) s = top;
    return s;
  endfunction

endpackage
`default_nettype wire

FILE: src/border_center_brightness_compare.sv
// top level: border band and center area brightness compare over one frame
//
// Usage: gray pixels arrive in raster order on the s_ channel, one request per
// pixel, s_tdata[7:0] = pixel and s_tuser[0] = frame_start. The block keeps its
// own row and column position; frame_start forces row 0, column 0 and clears
// the sums before that pixel is counted. Frame size and band sizes come from
// the write port (cfg_we, cfg_addr, cfg_data); the user must change them only
// while idle; the block does not enforce it. One pixel is taken per cycle
// while s_tready is high. After the last pixel of a frame a single result
// request leaves on the m_ channel: totals are captured, then the two cross
// products are formed in one multiplier stage, then the compare fills the
// output register. s_tready drops only when every stage holds a result and
// m_tready is low, so pixels keep flowing while one result waits.
// Reset (synchronous rst) restores the default 480x640 frame with 29-row and
// 96-column bands, sets the position to the first pixel and clears all sums.
`default_nettype none
module border_center_brightness_compare (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output      logic                             s_tready,
  // pixel
  input  wire logic [bcbc_pkg::IN_TDATA_W-1:0]  s_tdata,
  // frame_start
  input  wire logic [bcbc_pkg::IN_TUSER_W-1:0]  s_tuser,
  output      logic                             m_tvalid,
  input  wire logic                             m_tready,
  // mask_needed, border_sum, border_pixels, center_sum, center_pixels, zero pad
  output      logic [bcbc_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  wire logic                             cfg_we,
  input  wire logic [bcbc_pkg::CADDR_W-1:0]     cfg_addr,
  input  wire logic [bcbc_pkg::CFG_W-1:0]       cfg_data
);
  import bcbc_pkg::*;

  localparam logic [CFG_W-1:0] MAX_ROWS_C = CFG_W'(MAX_ROWS);
  localparam logic [CFG_W-1:0] MAX_COLS_C = CFG_W'(MAX_COLS);

  logic [CFG_W-1:0]  frame_rows;
  logic [CFG_W-1:0]  frame_cols;
  logic [CFG_W-1:0]  margin_rows;
  logic [CFG_W-1:0]  margin_cols;

  logic [ROW_W-1:0]  row_index;
  logic [COL_W-1:0]  col_index;
  logic [BSUM_W-1:0] border_accum;
  logic [BCNT_W-1:0] border_tally;
  logic [CSUM_W-1:0] center_accum;
  logic [CCNT_W-1:0] center_tally;

  logic [ROW_W-1:0]  row_index_next;
  logic [COL_W-1:0]  col_index_next;
  logic [BSUM_W-1:0] border_accum_next;
  logic [BCNT_W-1:0] border_tally_next;
  logic [CSUM_W-1:0] center_accum_next;
  logic [CCNT_W-1:0] center_tally_next;
  logic              frame_done;
  totals_t           totals_next;

  logic              s1_valid;
  totals_t           s1_totals;
  logic              s2_valid;
  totals_t           s2_totals;
  logic [LHS_W-1:0]  s2_lhs;
  logic [RHS_W-1:0]  s2_rhs;

  logic              out_free;
  logic              s2_free;
  logic              s1_free;
  logic              pix_take;
  logic              mask_next;

  assign out_free = !m_tvalid || m_tready;
  assign s2_free  = !s2_valid || out_free;
  assign s1_free  = !s1_valid || s2_free;
  assign s_tready = s1_free;
  assign pix_take = s_tvalid && s_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_rows  <= RST_FRAME_ROWS;
      frame_cols  <= RST_FRAME_COLS;
      margin_rows <= RST_MARGIN_ROWS;
      margin_cols <= RST_MARGIN_COLS;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FRAME_ROWS:  frame_rows  <= cfg_data;
        REG_FRAME_COLS:  frame_cols  <= cfg_data;
        REG_MARGIN_ROWS: margin_rows <= cfg_data;
        REG_MARGIN_COLS: margin_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  // band membership and accumulation for the pixel being taken
  always_comb begin
    logic [CFG_W-1:0]        nr;
    logic [CFG_W-1:0]        nc;
    logic signed [CFG_W+1:0] r_s;
    logic signed [CFG_W+1:0] c_s;
    logic signed [CFG_W+1:0] mr_s;
    logic signed [CFG_W+1:0] mc_s;
    logic signed [CFG_W+1:0] row_hi;
    logic signed [CFG_W+1:0] col_hi;
    logic [ROW_W-1:0]        r;
    logic [COL_W-1:0]        c;
    logic [BSUM_W-1:0]       bacc;
    logic [BCNT_W-1:0]       btal;
    logic [CSUM_W-1:0]       cacc;
    logic [CCNT_W-1:0]       ctal;
    logic                    mid_rows;
    logic                    left_cols;
    logic                    in_left;
    logic                    in_right;
    logic                    in_top;
    logic                    in_bottom;
    logic                    in_center;
    logic [HITS_W-1:0]       hits;
    logic [PIX_W+HITS_W-1:0] weighted;
    logic                    last_col;
    logic                    last_row;

    nr = clamp_size(frame_rows, MAX_ROWS_C);
    nc = clamp_size(frame_cols, MAX_COLS_C);

    if (s_tuser[0]) begin
      r    = '0;
      c    = '0;
      bacc = '0;
      btal = '0;
      cacc = '0;
      ctal = '0;
    end else begin
      r    = row_index;
      c    = col_index;
      bacc = border_accum;
      btal = border_tally;
      cacc = center_accum;
      ctal = center_tally;
    end

    r_s    = $signed({{(CFG_W+2-ROW_W){1'b0}}, r});
    c_s    = $signed({{(CFG_W+2-COL_W){1'b0}}, c});
    mr_s   = $signed({2'b00, margin_rows});
    mc_s   = $signed({2'b00, margin_cols});
    row_hi = $signed({2'b00, nr}) - mr_s;
    col_hi = $signed({2'b00, nc}) - mc_s;

    mid_rows  = (r_s >= mr_s) && (r_s < row_hi);
    left_cols = c_s < mc_s;
    in_left   = mid_rows && left_cols;
    in_right  = mid_rows && (c_s >= col_hi);
    in_top    = (r_s < mr_s) && left_cols;
    in_bottom = (r_s >= row_hi) && left_cols;
    in_center = mid_rows && !left_cols && (c_s < col_hi);

    hits = HITS_W'(in_left) + HITS_W'(in_right) + HITS_W'(in_top) + HITS_W'(in_bottom);
    // hits is at most two, so this is a shift and add
    weighted = (PIX_W+HITS_W)'(s_tdata[PIX_W-1:0]) * (PIX_W+HITS_W)'(hits);

    border_accum_next = bacc + BSUM_W'(weighted);
    border_tally_next = btal + BCNT_W'(hits);
    center_accum_next = in_center ? cacc + CSUM_W'(s_tdata[PIX_W-1:0]) : cacc;
    center_tally_next = in_center ? ctal + CCNT_W'(1) : ctal;

    // a position at or past the last index counts as the last one
    last_col = {1'b0, c} >= (nc - CFG_W'(1));
    last_row = {1'b0, r} >= (nr - CFG_W'(1));

    row_index_next = r;
    col_index_next = c + COL_W'(1);
    frame_done     = 1'b0;
    if (last_col) begin
      col_index_next = '0;
      if (last_row) begin
        row_index_next = '0;
        frame_done     = 1'b1;
      end else begin
        row_index_next = r + ROW_W'(1);
      end
    end

    totals_next.bsum = border_accum_next;
    totals_next.bcnt = border_tally_next;
    totals_next.csum = center_accum_next;
    totals_next.ccnt = center_tally_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_index    <= '0;
      col_index    <= '0;
      border_accum <= '0;
      border_tally <= '0;
      center_accum <= '0;
      center_tally <= '0;
    end else if (pix_take) begin
      row_index <= row_index_next;
      col_index <= col_index_next;
      if (frame_done) begin
        border_accum <= '0;
        border_tally <= '0;
        center_accum <= '0;
        center_tally <= '0;
      end else begin
        border_accum <= border_accum_next;
        border_tally <= border_tally_next;
        center_accum <= center_accum_next;
        center_tally <= center_tally_next;
      end
    end
  end

  // result pipeline: captured totals, cross products, compare
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s1_free) s1_valid <= pix_take && frame_done;
      if (s2_free) s2_valid <= s1_valid;
      if (out_free) m_tvalid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && pix_take && frame_done) s1_totals <= totals_next;
    if (s2_free && s1_valid) begin
      s2_totals <= s1_totals;
      s2_lhs    <= LHS_W'(s1_totals.bsum) * LHS_W'(s1_totals.ccnt);
      s2_rhs    <= RHS_W'(s1_totals.csum) * RHS_W'(s1_totals.bcnt);
    end
    if (out_free && s2_valid) begin
      m_tdata <= {{(OUT_TDATA_W-OUT_FIELD_W){1'b0}},
                  s2_totals.ccnt, s2_totals.csum, s2_totals.bcnt, s2_totals.bsum,
                  mask_next};
    end
  end

  assign mask_next = (s2_totals.bcnt != '0) && (s2_totals.ccnt != '0) &&
                     (PROD_W'(s2_lhs) > PROD_W'(s2_rhs));

endmodule
`default_nettype wire

FILE: tb/bcbc_frame_checker.sv
// frame checker: tracks border and center sums per frame and compares the result requests
module bcbc_frame_checker import bcbc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic [IN_TUSER_W-1:0]  s_tuser,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_we,
  input  logic [CADDR_W-1:0]     cfg_addr,
  input  logic [CFG_W-1:0]       cfg_data,
  output int                     mismatch_count,
  output int                     results_owed,
  output int                     frames_checked,
  output int                     masks_set
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic    mask;
    totals_t sums;
  } frame_verdict_t;

  frame_verdict_t expected_verdicts[$];

  logic [CFG_W-1:0]  rows_reg, cols_reg, mrows_reg, mcols_reg;
  int                row_pos, col_pos;
  logic [BSUM_W-1:0] border_acc;
  logic [BCNT_W-1:0] border_cnt;
  logic [CSUM_W-1:0] center_acc;
  logic [CCNT_W-1:0] center_cnt;

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 40) $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int top);
    int s;
    s = int'(v);
    if (s < 1) s = 1;
    if (s > top) s = top;
    return s;
  endfunction

  task automatic clear_sums();
    border_acc = '0;
    border_cnt = '0;
    center_acc = '0;
    center_cnt = '0;
  endtask

  task automatic accumulate_pixel(input logic [PIX_W-1:0] px, input logic fs);
    int nr, nc, mr, mc, r, c, hits;
    logic mid_rows;
    logic [63:0] lhs, rhs;
    frame_verdict_t v;
    nr = clamp_dim(rows_reg, MAX_ROWS);
    nc = clamp_dim(cols_reg, MAX_COLS);
    mr = int'(mrows_reg);
    mc = int'(mcols_reg);
    if (fs) begin
      row_pos = 0;
      col_pos = 0;
      clear_sums();
    end
    r = row_pos;
    c = col_pos;
    // a pixel counts once per band that holds it
    mid_rows = (r >= mr) && (r < nr - mr);
    hits = 0;
    if (mid_rows && c < mc) hits++;
    if (mid_rows && c >= nc - mc) hits++;
    if (r < mr && c < mc) hits++;
    if (r >= nr - mr && c < mc) hits++;
    border_acc = border_acc + BSUM_W'(hits * int'(px));
    border_cnt = border_cnt + BCNT_W'(hits);
    if (mid_rows && c >= mc && c < nc - mc) begin
      center_acc = center_acc + CSUM_W'(px);
      center_cnt = center_cnt + 1'b1;
    end
    if (c < nc - 1) begin
      col_pos++;
    end else begin
      col_pos = 0;
      if (r < nr - 1) begin
        row_pos++;
      end else begin
        // exact mean compare by cross products
        lhs = 64'(border_acc) * 64'(center_cnt);
        rhs = 64'(center_acc) * 64'(border_cnt);
        v.mask = (border_cnt != 0) && (center_cnt != 0) && (lhs > rhs);
        v.sums.bsum = border_acc;
        v.sums.bcnt = border_cnt;
        v.sums.csum = center_acc;
        v.sums.ccnt = center_cnt;
        expected_verdicts.push_back(v);
        row_pos = 0;
        clear_sums();
      end
    end
  endtask

  task automatic check_result(input logic [OUT_TDATA_W-1:0] word);
    frame_verdict_t want;
    logic got_mask;
    totals_t got;
    got_mask = word[0];
    got = word[OUT_FIELD_W-1:1];
    if (expected_verdicts.size() == 0) begin
      report_mismatch($sformatf("result request with no frame pending, tdata %h", word));
    end else begin
      want = expected_verdicts.pop_front();
      frames_checked++;
      if (want.mask) masks_set++;
      if (got_mask !== want.mask)
        report_mismatch($sformatf("mask_needed expected %0d got %0d", want.mask, got_mask));
      if (got.bsum !== want.sums.bsum)
        report_mismatch($sformatf("border_sum expected %0d got %0d", want.sums.bsum, got.bsum));
      if (got.bcnt !== want.sums.bcnt)
        report_mismatch($sformatf("border_pixels expected %0d got %0d",
                                  want.sums.bcnt, got.bcnt));
      if (got.csum !== want.sums.csum)
        report_mismatch($sformatf("center_sum expected %0d got %0d", want.sums.csum, got.csum));
      if (got.ccnt !== want.sums.ccnt)
        report_mismatch($sformatf("center_pixels expected %0d got %0d",
                                  want.sums.ccnt, got.ccnt));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rows_reg = RST_FRAME_ROWS;
      cols_reg = RST_FRAME_COLS;
      mrows_reg = RST_MARGIN_ROWS;
      mcols_reg = RST_MARGIN_COLS;
      row_pos = 0;
      col_pos = 0;
      clear_sums();
      expected_verdicts.delete();
      mismatch_count = 0;
      results_owed = 0;
      frames_checked = 0;
      masks_set = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_FRAME_ROWS:  rows_reg = cfg_data;
          REG_FRAME_COLS:  cols_reg = cfg_data;
          REG_MARGIN_ROWS: mrows_reg = cfg_data;
          REG_MARGIN_COLS: mcols_reg = cfg_data;
          default: ;
        endcase
      end
      // results first: a pixel taken now cannot finish at this edge
      if (m_tvalid && m_tready) check_result(m_tdata);
      if (s_tvalid && s_tready) accumulate_pixel(s_tdata[PIX_W-1:0], s_tuser[0]);
      results_owed = expected_verdicts.size();
    end
  end

endmodule

FILE: tb/tb_border_center_brightness_compare.sv
// testbench top: pixel stimulus, register settings and final verdict for the brightness compare
module tb_border_center_brightness_compare;
  timeunit 1ns;
  timeprecision 1ps;
  import bcbc_pkg::*;

  typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [IN_TUSER_W-1:0]  s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_we = 1'b0;
  logic [CADDR_W-1:0]     cfg_addr = '0;
  logic [CFG_W-1:0]       cfg_data = '0;

  int mismatch_count, results_owed, frames_checked, masks_set;
  int burst_left = 0;
  int pixels_sent = 0;
  int settings_used = 0;

  rx_mode_t rx_mode = RX_ALWAYS;
  int       rx_left = 0;

  border_center_brightness_compare dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  bcbc_frame_checker frame_check (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed),
    .frames_checked (frames_checked),
    .masks_set      (masks_set)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver: modes that change every so often, the last one gives ready only when rx_left[3:0] is zero
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(16, 160);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_ALWAYS: m_tready <= 1'b1;
      RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
      default:   m_tready <= (rx_left[3:0] == 4'd0);
    endcase
  end

  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic fs);
    if (burst_left == 0) begin
      // gap between bursts, with junk on the idle bus
      s_tvalid <= 1'b0;
      s_tdata <= IN_TDATA_W'($urandom);
      s_tuser <= IN_TUSER_W'($urandom);
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 240) : $urandom_range(1, 20);
    end
    s_tvalid <= 1'b1;
    s_tdata <= px;
    s_tuser <= fs;
    do @(posedge clk); while (!s_tready);
    burst_left--;
    pixels_sent++;
  endtask

  // drain all results, then let the pipeline settle before touching registers
  task automatic end_phase();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (results_owed != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_config(input logic [CFG_W-1:0] rows, cols, mrows, mcols);
    cfg_we <= 1'b1;
    cfg_addr <= REG_FRAME_ROWS;
    cfg_data <= rows;
    @(posedge clk);
    cfg_addr <= REG_FRAME_COLS;
    cfg_data <= cols;
    @(posedge clk);
    cfg_addr <= REG_MARGIN_ROWS;
    cfg_data <= mrows;
    @(posedge clk);
    cfg_addr <= REG_MARGIN_COLS;
    cfg_data <= mcols;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  function automatic int pick_size(input int top);
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 1;
      default: return $urandom_range(1, top);
    endcase
  endfunction

  // margins past the frame make bands overlap or vanish
  function automatic int pick_margin(input int dim);
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 1024;
      2: return 2047;
      3: return dim;
      4: return dim + 1;
      default: return $urandom_range(0, (dim + 1) / 2);
    endcase
  endfunction

  task automatic run_random_phase(input int target);
    int rows, cols, frame_len, n, p;
    logic fs;
    rows = pick_size(6);
    cols = pick_size(8);
    write_config(CFG_W'(rows), CFG_W'(cols), CFG_W'(pick_margin(rows)),
                 CFG_W'(pick_margin(cols)));
    frame_len = ((rows == 0) ? 1 : rows) * ((cols == 0) ? 1 : cols);
    n = 0;
    while (n < target) begin
      for (p = 0; p < frame_len && n < target; p++) begin
        // mostly whole frames, now and then a restart in the middle
        fs = (p == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 39) == 0);
        send_pixel(pick_pixel(), fs);
        n++;
      end
    end
    end_phase();
  endtask

  // start of a large frame, then a one-pixel size makes the next pixel the last one
  task automatic run_big_frame(input logic [CFG_W-1:0] rows, cols, mrows, mcols, input int len);
    int i;
    write_config(rows, cols, mrows, mcols);
    for (i = 0; i < len; i++) send_pixel(pick_pixel(), i == 0);
    end_phase();
    write_config(11'd1, 11'd1, mrows, mcols);
    send_pixel(pick_pixel(), 1'b0);
    end_phase();
  endtask

  initial begin
    int i, waited;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // 2x3 frame, left and right columns border, middle column center
    write_config(11'd2, 11'd3, 11'd0, 11'd1);
    for (i = 0; i < 6; i++) send_pixel((i % 3 == 1) ? 8'd0 : 8'd255, i == 0);
    send_pixel(8'd77, 1'b0);
    send_pixel(8'd13, 1'b0);
    for (i = 0; i < 6; i++) send_pixel((i % 3 == 1) ? 8'd255 : 8'd0, i == 0);
    // equal means, frame taken up without a frame start
    for (i = 0; i < 6; i++) send_pixel(8'd255, 1'b0);
    end_phase();
    // no border bands at all
    write_config(11'd1, 11'd2, 11'd0, 11'd0);
    send_pixel(8'd200, 1'b1);
    send_pixel(8'd1, 1'b0);
    end_phase();
    // zero sizes clamp to a single pixel in the center
    write_config(11'd0, 11'd0, 11'd0, 11'd0);
    send_pixel(8'd128, 1'b0);
    end_phase();
    // oversized margins: top and bottom corners both hold the pixel
    write_config(11'd1, 11'd1, 11'd1024, 11'd1024);
    send_pixel(8'd255, 1'b1);
    end_phase();

    for (i = 0; i < 6; i++) run_random_phase($urandom_range(50, 70));

    // sizes past the maximum clamp, so the far bands start well inside the first pixels
    run_big_frame(11'd2047, 11'd1, 11'd900, 11'd1, 150);
    run_big_frame(11'd1, 11'd2047, 11'd0, 11'd900, 150);

    waited = 0;
    while (results_owed != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (results_owed != 0) $display("%0d frame results never arrived", results_owed);

    $display("%0d pixels over %0d register settings, including clamped and oversized bands",
             pixels_sent, settings_used);
    $display("%0d frame results checked, %0d of them with the mask set",
             frames_checked, masks_set);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("timeout with %0d frame results outstanding", results_owed);
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: sim.f
src/bcbc_pkg.sv
src/border_center_brightness_compare.sv
tb/bcbc_frame_checker.sv
tb/tb_border_center_brightness_compare.sv
